>>> design/md5s_pkg.sv
`default_nettype none
package md5s_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef logic [31:0] word_t;

    // control from sequencer to round core
    typedef struct packed {
        logic start;
        logic step;
        logic [5:0] rnd;
        logic fold;
    } core_ctl_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word index used by round i
    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
            2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
            default: g = 4'(i[3:0] * 4'd7);
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

>>> design/md5_stream_hash.sv
`default_nettype none
// absorb: one byte accepted per cycle while s_tready is high; the 64th byte of a block starts the rounds
// (load, first memory read, 64 rounds at one a cycle, fold into the chaining words)
// finish: padding and length writes, one or two compressions,
// then 4 digest words, one per cycle while m_tready is high; s_tready is low meanwhile
// reset: chaining words to the md5 iv, bit count to zero; block memory is not cleared
module md5_stream_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // data_byte[7:0]
    input  wire logic        s_tuser,  // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // digest_word[31:0]
    output logic [1:0]       m_tuser,  // word_index[1:0]
    output logic             m_tlast   // last_word
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] st_reg, st_next;
    logic [63:0] cnt_reg;
    logic [5:0] ptr_reg;       // byte pointer for padding
    logic [6:0] rc_reg;        // round counter, 66 = fold
    logic fin_reg;             // compression belongs to a finish
    logic two_reg;             // another block follows this compression
    logic [1:0] oi_reg;

    // message memory: 16 words with byte enables
    logic [31:0] mem [16];
    logic [31:0] rd_reg;
    logic        we;
    logic [3:0]  wa;
    logic [1:0]  wb;
    logic [7:0]  wd;
    logic [3:0]  ra;

    md5s_pkg::core_ctl_t ctl;
    md5s_pkg::word_t chain [4];
    logic reinit;

    md5s_round u_round (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .reinit(reinit), .m_word(rd_reg), .chain(chain)
    );

    wire s_acc = s_tvalid && s_tready;
    wire [5:0] fill = cnt_reg[8:3];

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tdata  = chain[oi_reg];
    assign m_tuser  = oi_reg;
    assign m_tlast  = (oi_reg == 2'd3);
    wire m_acc = m_tvalid && m_tready;
    assign reinit = m_acc && m_tlast;

    // read address runs one round ahead of the core
    wire [5:0] rnd_rd = 6'(rc_reg - 7'd1);
    assign ra = md5s_pkg::msg_idx(rnd_rd);

    always_comb
    begin
        we = 1'b0;
        wa = ptr_reg[5:2];
        wb = ptr_reg[1:0];
        wd = 8'h00;
        if (st_reg == ST_IDLE && s_acc)
        begin
            we = 1'b1;
            wa = fill[5:2];
            wb = fill[1:0];
            wd = (s_tuser == md5s_pkg::OP_FINISH) ? 8'h80 : s_tdata;
        end
        else if (st_reg == ST_PAD)
        begin
            we = 1'b1;
        end
        else if (st_reg == ST_LEN)
        begin
            we = 1'b1;
            wd = cnt_reg[8 * ptr_reg[2:0] +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa][8 * wb +: 8] <= wd;
        rd_reg <= mem[ra];
    end

    always_comb
    begin
        ctl.start = (st_reg == ST_RND) && (rc_reg == 7'd0);
        ctl.step  = (st_reg == ST_RND) && (rc_reg >= 7'd2) && (rc_reg <= 7'd65);
        ctl.rnd   = 6'(rc_reg - 7'd2);
        ctl.fold  = (st_reg == ST_RND) && (rc_reg == 7'd66);
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (s_acc)
                begin
                    if (s_tuser == md5s_pkg::OP_FINISH)
                        st_next = (fill == 6'd63) ? ST_RND
                                : ((fill == 6'd55) ? ST_LEN : ST_PAD);
                    else if (fill == 6'd63)
                        st_next = ST_RND;
                end
            ST_PAD:
                if (ptr_reg == 6'd55)
                    st_next = ST_LEN;
                else if (ptr_reg == 6'd63)
                    st_next = ST_RND;
            ST_LEN:
                if (ptr_reg == 6'd63)
                    st_next = ST_RND;
            ST_RND:
                if (rc_reg == 7'd66)
                    st_next = two_reg ? ST_PAD : (fin_reg ? ST_OUT : ST_IDLE);
            ST_OUT:
                if (reinit)
                    st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            cnt_reg <= '0;
            ptr_reg <= '0;
            rc_reg  <= '0;
            fin_reg <= 1'b0;
            two_reg <= 1'b0;
            oi_reg  <= '0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                ST_IDLE:
                    if (s_acc)
                    begin
                        rc_reg  <= '0;
                        ptr_reg <= 6'(fill + 6'd1);
                        oi_reg  <= '0;
                        if (s_tuser == md5s_pkg::OP_FINISH)
                        begin
                            fin_reg <= 1'b1;
                            // padding spills into a second block
                            two_reg <= (fill >= 6'd56);
                        end
                        else
                        begin
                            fin_reg <= 1'b0;
                            two_reg <= 1'b0;
                            cnt_reg <= cnt_reg + 64'd8;
                        end
                    end
                ST_PAD, ST_LEN:
                    ptr_reg <= ptr_reg + 6'd1;
                ST_RND:
                begin
                    rc_reg <= rc_reg + 7'd1;
                    if (rc_reg == 7'd66)
                    begin
                        rc_reg  <= '0;
                        two_reg <= 1'b0;
                        ptr_reg <= '0;
                    end
                end
                ST_OUT:
                    if (m_acc)
                    begin
                        oi_reg <= oi_reg + 2'd1;
                        if (m_tlast)
                            cnt_reg <= '0;
                    end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_rdy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid) else $error("input ready while digest pending");
    a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 2'd1))
        else $error("digest words out of order");
    a_fold_end: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fold |=> !(st_reg == ST_RND)) else $error("rounds continue after fold");
    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        reinit |=> cnt_reg == 64'd0) else $error("bit count not cleared");
`endif
endmodule
`default_nettype wire

>>> design/md5s_round.sv
`default_nettype none
module md5s_round (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire md5s_pkg::core_ctl_t   ctl,
    input  wire logic                  reinit,
    input  wire md5s_pkg::word_t       m_word,
    output md5s_pkg::word_t            chain [4]
);
    md5s_pkg::word_t a_reg, b_reg, c_reg, d_reg;
    md5s_pkg::word_t h_reg [4];
    md5s_pkg::word_t f, t, rot, rot2;
    logic [4:0] s;

    always_comb
    begin
        case (ctl.rnd[5:4])
            2'd0: f = d_reg ^ (b_reg & (c_reg ^ d_reg));
            2'd1: f = c_reg ^ (d_reg & (b_reg ^ c_reg));
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        t = a_reg + f + m_word + md5s_pkg::round_k(ctl.rnd);
        s = md5s_pkg::rot_amt(ctl.rnd);
        rot2 = 32'((({t, t}) << s) >> 32);
        rot = rot2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0] <= md5s_pkg::IV_A;
            h_reg[1] <= md5s_pkg::IV_B;
            h_reg[2] <= md5s_pkg::IV_C;
            h_reg[3] <= md5s_pkg::IV_D;
        end
        else if (reinit)
        begin
            h_reg[0] <= md5s_pkg::IV_A;
            h_reg[1] <= md5s_pkg::IV_B;
            h_reg[2] <= md5s_pkg::IV_C;
            h_reg[3] <= md5s_pkg::IV_D;
        end
        else if (ctl.fold)
        begin
            h_reg[0] <= h_reg[0] + a_reg;
            h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg;
            h_reg[3] <= h_reg[3] + d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
        end
        else if (ctl.step)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

    assign chain = h_reg;
endmodule
`default_nettype wire
